// ===== hw/rtl/tals_pkg.sv =====
// ----------------------------------------------------------------------------
// tals_pkg: shared types and constants for the two-axis line step generator
// Holds coordinate widths, step and opcode codes, and the item structs of the
// input and result channels.
// ----------------------------------------------------------------------------
package tals_pkg;

  // Width of the stored axis positions; they wrap at this width.
  localparam int COORD_BITS = 16;

  // Width of the coordinate fields on the channels.
  localparam int FIELD_BITS = 16;

  // Signed move delta: target minus position, without wrap.
  localparam int DELTA_W = ((COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS) + 1;

  // Unsigned major length and step count.
  localparam int LEN_W = DELTA_W;

  // Rounding residue; stays within half a major length plus one minor delta.
  localparam int ERR_W = DELTA_W + 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_UP   = 2'd1;
  localparam logic [1:0] STEP_DOWN = 2'd2;

  typedef struct packed {
    logic                         opcode;
    logic signed [FIELD_BITS-1:0] target_a;
    logic signed [FIELD_BITS-1:0] target_b;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                   step_a;
    logic [1:0]                   step_b;
    logic                         busy_res;
    logic                         rejected;
    logic signed [FIELD_BITS-1:0] position_a;
    logic signed [FIELD_BITS-1:0] position_b;
  } out_item_t;

endpackage

// ===== hw/rtl/two_axis_line_step_generator.sv =====
// ----------------------------------------------------------------------------
// two_axis_line_step_generator: straight-line stepper for two axes
// Loads a target, then steps the major axis once per tick while the minor
// axis follows the exactly rounded ideal line.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one item per handshake. opcode OP_LOAD starts a move toward
//           (target_a, target_b); opcode OP_TICK advances the move by one
//           major-axis step. A load that arrives while a move is running is
//           dropped and answered with rejected set.
//   out_* : exactly one result item per input item, in order: the step
//           codes of this item, whether steps remain, and both positions.
//   Path: an accepted item lands in the input register, then moves on into
//           the result register, which drives out_valid.
//   Throughput: one item per cycle while out_ready allows; the tick update is
//           adds and compares on the residue, the load a subtract and magnitude compare.
//   Stall: while out_ready is low the result register holds; the input
//           register still takes one more item, then in_ready drops.
//   Reset: rst_n low clears both valid flags, both positions, the step count
//           and the move direction; no item is in flight afterward.
// ----------------------------------------------------------------------------
module two_axis_line_step_generator
  import tals_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Pipeline registers
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  // Move state
  logic        [COORD_BITS-1:0] pos_a_r, pos_a_nxt;
  logic        [COORD_BITS-1:0] pos_b_r, pos_b_nxt;
  logic        [LEN_W-1:0]      steps_left_r, steps_left_nxt;
  logic                         major_is_a_r, major_is_a_nxt;
  logic                         major_down_r, major_down_nxt;
  logic signed [DELTA_W-1:0]    minor_delta_r, minor_delta_nxt;
  logic        [LEN_W-1:0]      major_length_r, major_length_nxt;
  logic signed [ERR_W-1:0]      err_r, err_nxt;

  out_item_t result_nxt;
  logic      advance;

  // Result register frees up when empty or being taken.
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // ---------------------------------------------------------------- load path
  logic signed [DELTA_W-1:0] da, db;
  logic        [LEN_W-1:0]   da_abs, db_abs;
  logic                      load_a_major;

  assign da = DELTA_W'(s1_item_r.target_a) - DELTA_W'(signed'(pos_a_r));
  assign db = DELTA_W'(s1_item_r.target_b) - DELTA_W'(signed'(pos_b_r));
  assign da_abs = da[DELTA_W-1] ? LEN_W'(-da) : LEN_W'(da);
  assign db_abs = db[DELTA_W-1] ? LEN_W'(-db) : LEN_W'(db);
  assign load_a_major = (da_abs >= db_abs);

  // ---------------------------------------------------------------- tick path
  logic signed [ERR_W-1:0] t_sum, len_e;
  logic signed [ERR_W:0]   t_dbl, len_x;
  logic [COORD_BITS-1:0]   minor_pos, major_pos, minor_pos_nxt, major_pos_nxt;
  logic                    minor_up, minor_down, p_nonneg, p_nonpos;

  assign t_sum = err_r + ERR_W'(minor_delta_r);
  assign t_dbl = {t_sum, 1'b0};
  assign len_e = signed'(ERR_W'(major_length_r));
  assign len_x = signed'((ERR_W + 1)'(major_length_r));

  assign minor_pos = major_is_a_r ? pos_b_r : pos_a_r;
  assign major_pos = major_is_a_r ? pos_a_r : pos_b_r;
  assign p_nonneg  = !minor_pos[COORD_BITS-1];
  assign p_nonpos  = minor_pos[COORD_BITS-1] || (minor_pos == '0);

  // Round to nearest; exact halves go away from zero on the absolute coordinate.
  assign minor_up   = (t_dbl > len_x)  || ((t_dbl == len_x) && p_nonneg);
  assign minor_down = (t_dbl < -len_x) || ((t_dbl == -len_x) && p_nonpos);

  assign major_pos_nxt = major_down_r ? major_pos - 1'b1 : major_pos + 1'b1;
  assign minor_pos_nxt = minor_up   ? minor_pos + 1'b1 :
                         minor_down ? minor_pos - 1'b1 : minor_pos;

  // ------------------------------------------------------------ next state
  always_comb begin
    logic [1:0] major_code;
    logic [1:0] minor_code;
    logic       rej;
    logic       stepping;

    pos_a_nxt        = pos_a_r;
    pos_b_nxt        = pos_b_r;
    steps_left_nxt   = steps_left_r;
    major_is_a_nxt   = major_is_a_r;
    major_down_nxt   = major_down_r;
    minor_delta_nxt  = minor_delta_r;
    major_length_nxt = major_length_r;
    err_nxt          = err_r;
    rej              = 1'b0;
    stepping         = 1'b0;

    major_code = major_down_r ? STEP_DOWN : STEP_UP;
    minor_code = minor_up ? STEP_UP : (minor_down ? STEP_DOWN : STEP_NONE);

    if (s1_item_r.opcode == OP_LOAD) begin
      if (steps_left_r != '0) begin
        // Drop a load while a move runs.
        rej = 1'b1;
      end else begin
        major_is_a_nxt   = load_a_major;
        major_down_nxt   = load_a_major ? da[DELTA_W-1] : db[DELTA_W-1];
        major_length_nxt = load_a_major ? da_abs : db_abs;
        minor_delta_nxt  = load_a_major ? db : da;
        err_nxt          = '0;
        steps_left_nxt   = load_a_major ? da_abs : db_abs;
      end
    end else if (steps_left_r != '0) begin
      stepping       = 1'b1;
      steps_left_nxt = steps_left_r - 1'b1;
      if (minor_up) begin
        err_nxt = t_sum - len_e;
      end else if (minor_down) begin
        err_nxt = t_sum + len_e;
      end else begin
        err_nxt = t_sum;
      end
      if (major_is_a_r) begin
        pos_a_nxt = major_pos_nxt;
        pos_b_nxt = minor_pos_nxt;
      end else begin
        pos_b_nxt = major_pos_nxt;
        pos_a_nxt = minor_pos_nxt;
      end
    end

    result_nxt.step_a     = !stepping ? STEP_NONE : (major_is_a_r ? major_code : minor_code);
    result_nxt.step_b     = !stepping ? STEP_NONE : (major_is_a_r ? minor_code : major_code);
    result_nxt.busy_res   = (steps_left_nxt != '0);
    result_nxt.rejected   = rej;
    result_nxt.position_a = FIELD_BITS'(signed'(pos_a_nxt));
    result_nxt.position_b = FIELD_BITS'(signed'(pos_b_nxt));
  end

  // -------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      pos_a_r        <= '0;
      pos_b_r        <= '0;
      steps_left_r   <= '0;
      major_is_a_r   <= 1'b1;
      major_down_r   <= 1'b0;
      minor_delta_r  <= '0;
      major_length_r <= '0;
      err_r          <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      // Commit the state update only when the result moves into the result register.
      if (advance && s1_valid_r) begin
        pos_a_r        <= pos_a_nxt;
        pos_b_r        <= pos_b_nxt;
        steps_left_r   <= steps_left_nxt;
        major_is_a_r   <= major_is_a_nxt;
        major_down_r   <= major_down_nxt;
        minor_delta_r  <= minor_delta_nxt;
        major_length_r <= major_length_nxt;
        err_r          <= err_nxt;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
    if (advance && s1_valid_r) begin
      out_item_r <= result_nxt;
    end
  end

endmodule

// ===== hw/rtl/tals_checker.sv =====
// ----------------------------------------------------------------------------
// tals_checker: port-level checks for the two-axis line step generator
// Watches the result channel for handshake holding, legal result codes, rejected loads and an empty result after reset.
// ----------------------------------------------------------------------------
module tals_checker
  import tals_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_step_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.step_a != 2'd3 && out_data.step_b != 2'd3)
    else $error("illegal step code");

  // A rejected load moves nothing and reports the running move.
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rejected |->
      out_data.step_a == STEP_NONE && out_data.step_b == STEP_NONE && out_data.busy_res)
    else $error("rejected load with steps or not busy");

  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind two_axis_line_step_generator tals_checker u_tals_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: two-axis line step generator
// Drives load and tick items through the valid/ready input channel, predicts
// every result item with a cycle-free model of the line interpolator, and
// checks each result field by field in order. A short directed walk covers
// reset, zero distance, rejected loads with extreme targets, rounding halves
// and both major-axis choices; random move sequences with random handshake
// gaps follow, and the last running move is ticked to its end.
// ----------------------------------------------------------------------------
module testbench;
  import tals_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIR_ROWS       = 23;
  localparam int RAND_MOVES     = 740;   // effective items in the random part
  localparam int HOLD_AT        = 150;   // result count that starts the long stall
  localparam int HOLD_LEN       = 300;   // cycles of the long receiver stall
  localparam int DRAIN_CYCLES   = 8;     // idle cycles at the end, past the two-stage pipeline
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
  localparam int PRINT_LIMIT    = 50;

  typedef struct {
    in_item_t  item;
    bit        has_fixed;  // set when the result is typed in below
    out_item_t fixed;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Shadow of the block's move state.
  logic [COORD_BITS-1:0] cur_a = '0;
  logic [COORD_BITS-1:0] cur_b = '0;
  logic [LEN_W-1:0]      moves_left = '0;
  logic                  a_leads = 1'b1;
  logic                  lead_down = 1'b0;
  longint                follow_delta = 0;
  longint                lead_len = 0;
  longint                residue = 0;

  out_item_t awaited_steps[$];
  out_item_t next_awaited;
  plan_row_t plan_rows [DIR_ROWS];

  int snd_idle_pct = 33;
  int rcv_idle_pct = 87;
  int mismatches = 0;
  int results_taken = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  two_axis_line_step_generator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Build items; ticks carry random targets so the ignored bits toggle too.
  function automatic in_item_t load_item(input int ta, input int tb);
    in_item_t it;
    it.opcode   = OP_LOAD;
    it.target_a = FIELD_BITS'(ta);
    it.target_b = FIELD_BITS'(tb);
    return it;
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    it.opcode   = OP_TICK;
    it.target_a = FIELD_BITS'($urandom);
    it.target_b = FIELD_BITS'($urandom);
    return it;
  endfunction

  function automatic out_item_t want(input logic [1:0] sa, input logic [1:0] sb,
                                     input logic busy, input logic rej,
                                     input int pa, input int pb);
    out_item_t r;
    r.step_a     = sa;
    r.step_b     = sb;
    r.busy_res   = busy;
    r.rejected   = rej;
    r.position_a = FIELD_BITS'(pa);
    r.position_b = FIELD_BITS'(pb);
    return r;
  endfunction

  // Advance the shadow state by one item and return the step result it causes.
  function automatic out_item_t advance_stepper(input in_item_t it);
    out_item_t  r;
    longint     d_a, d_b, lead, follow, t, p;
    int         dir, lead_dir;
    logic [1:0] lead_code, follow_code;
    r = '0;
    if (it.opcode == OP_LOAD) begin
      if (moves_left != 0) begin
        // Busy: drop the load, flag it.
        r.rejected = 1'b1;
      end else begin
        d_a          = longint'(it.target_a) - longint'($signed(cur_a));
        d_b          = longint'(it.target_b) - longint'($signed(cur_b));
        // A leads on ties.
        a_leads      = ((d_a < 0) ? -d_a : d_a) >= ((d_b < 0) ? -d_b : d_b);
        lead         = a_leads ? d_a : d_b;
        follow       = a_leads ? d_b : d_a;
        lead_down    = lead < 0;
        lead_len     = lead_down ? -lead : lead;
        follow_delta = follow;
        residue      = 0;
        moves_left   = LEN_W'(lead_len);
      end
    end else if (moves_left != 0) begin
      t   = residue + follow_delta;
      p   = a_leads ? longint'($signed(cur_b)) : longint'($signed(cur_a));
      dir = 0;
      if (2 * t > lead_len) begin
        dir = 1;
      end else if (2 * t < -lead_len) begin
        dir = -1;
      end else if (2 * t == lead_len) begin
        // Exact half upward: round away from zero on the absolute coordinate.
        dir = (p >= 0) ? 1 : 0;
      end else if (2 * t == -lead_len) begin
        dir = (p <= 0) ? -1 : 0;
      end
      residue     = t - lead_len * dir;
      lead_dir    = lead_down ? -1 : 1;
      lead_code   = lead_down ? STEP_DOWN : STEP_UP;
      follow_code = (dir > 0) ? STEP_UP : ((dir < 0) ? STEP_DOWN : STEP_NONE);
      if (a_leads) begin
        cur_a    = cur_a + COORD_BITS'(lead_dir);
        cur_b    = cur_b + COORD_BITS'(dir);
        r.step_a = lead_code;
        r.step_b = follow_code;
      end else begin
        cur_b    = cur_b + COORD_BITS'(lead_dir);
        cur_a    = cur_a + COORD_BITS'(dir);
        r.step_b = lead_code;
        r.step_a = follow_code;
      end
      moves_left = moves_left - 1'b1;
    end
    r.busy_res   = (moves_left != 0);
    r.position_a = FIELD_BITS'(longint'($signed(cur_a)));
    r.position_b = FIELD_BITS'(longint'($signed(cur_b)));
    return r;
  endfunction

  // Random coordinate within span of the current one, clamped to the field.
  function automatic int near_coord(input logic [COORD_BITS-1:0] at, input int span);
    longint v;
    v = longint'($signed(at)) + longint'($urandom_range(2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return int'(v);
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint exp_v);
    if (mismatches < PRINT_LIMIT) begin
      $display("mismatch on result %0d, %s: got %0d, expected %0d",
               results_taken, field, got, exp_v);
    end
    mismatches++;
  endtask

  // Offer one item, hold it until taken, then record the result it should cause.
  // Leave in_valid high on return: the caller either sends again in the same
  // step or lowers it itself.
  task automatic send_item(input in_item_t it, input bit has_fixed, input out_item_t fixed);
    out_item_t predicted;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predicted = advance_stepper(it);
    awaited_steps.push_back(has_fixed ? fixed : predicted);
  endtask

  // Receiver: check each taken result, then pick the next ready. Values read
  // here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_steps.size() == 0) begin
        report_mismatch("result with nothing awaited", 0, 0);
      end else begin
        next_awaited = awaited_steps.pop_front();
        if (out_data.step_a !== next_awaited.step_a)
          report_mismatch("step_a", out_data.step_a, next_awaited.step_a);
        if (out_data.step_b !== next_awaited.step_b)
          report_mismatch("step_b", out_data.step_b, next_awaited.step_b);
        if (out_data.busy_res !== next_awaited.busy_res)
          report_mismatch("busy_res", out_data.busy_res, next_awaited.busy_res);
        if (out_data.rejected !== next_awaited.rejected)
          report_mismatch("rejected", out_data.rejected, next_awaited.rejected);
        if (out_data.position_a !== next_awaited.position_a)
          report_mismatch("position_a", longint'(out_data.position_a),
                          longint'(next_awaited.position_a));
        if (out_data.position_b !== next_awaited.position_b)
          report_mismatch("position_b", longint'(out_data.position_b),
                          longint'(next_awaited.position_b));
      end
      results_taken++;
    end
    // Hold off once for a long stretch so the block fills and drops in_ready.
    if (results_taken >= HOLD_AT && !hold_done) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Watchdog: end the run when no handshake happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("two_axis_line_step_generator test failed");
      $finish;
    end
  end

  initial begin
    int        moved;
    int        roll;
    int        span;
    bit        paused;
    in_item_t  it;

    // Directed walk; typed-in results only where they are plain to read.
    plan_rows = '{
      // Tick while idle right after reset.
      '{tick_item(), 1'b1, want(STEP_NONE, STEP_NONE, 1'b0, 1'b0, 0, 0)},
      // Load with zero distance starts nothing.
      '{load_item(0, 0), 1'b1, want(STEP_NONE, STEP_NONE, 1'b0, 1'b0, 0, 0)},
      '{load_item(3, 1), 1'b1, want(STEP_NONE, STEP_NONE, 1'b1, 1'b0, 0, 0)},
      // Loads while busy, with extreme targets: dropped and flagged.
      '{load_item(32767, -32768), 1'b1, want(STEP_NONE, STEP_NONE, 1'b1, 1'b1, 0, 0)},
      '{load_item(-32768, 32767), 1'b1, want(STEP_NONE, STEP_NONE, 1'b1, 1'b1, 0, 0)},
      '{tick_item(), 1'b0, '0},
      '{tick_item(), 1'b0, '0},
      '{tick_item(), 1'b0, '0},
      '{tick_item(), 1'b1, want(STEP_NONE, STEP_NONE, 1'b0, 1'b0, 3, 1)},
      // Exact half on the first tick, minor position positive: step up.
      '{load_item(5, 2), 1'b0, '0},
      '{tick_item(), 1'b0, '0},
      '{tick_item(), 1'b0, '0},
      '{load_item(5, 2), 1'b1, want(STEP_NONE, STEP_NONE, 1'b0, 1'b0, 5, 2)},
      // Downward move with a negative exact half at a positive minor position.
      '{load_item(-1, 1), 1'b0, '0},
      '{tick_item(), 1'b0, '0},
      '{tick_item(), 1'b0, '0},
      '{tick_item(), 1'b0, '0},
      '{tick_item(), 1'b0, '0},
      '{tick_item(), 1'b0, '0},
      '{tick_item(), 1'b0, '0},
      // B leads; the move runs on into the random part.
      '{load_item(-1, 5), 1'b0, '0},
      '{tick_item(), 1'b0, '0},
      '{tick_item(), 1'b0, '0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(plan_rows[i].item, plan_rows[i].has_fixed, plan_rows[i].fixed);
    end

    // Random moves: mostly loads toward nearby targets followed by ticks,
    // with stray rejected loads, idle ticks and zero-distance loads mixed in.
    moved  = 0;
    paused = 1'b0;
    while (moved < RAND_MOVES) begin
      if (moved < RAND_MOVES / 3) begin
        snd_idle_pct = 33;
        rcv_idle_pct = 87;
      end else if (moved < 2 * RAND_MOVES / 3) begin
        snd_idle_pct = 87;
        rcv_idle_pct = 33;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      // Pause once until every awaited result has come back.
      if (!paused && moved >= RAND_MOVES / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited_steps.size() != 0);
      end
      roll = $urandom_range(99);
      if (moves_left != 0) begin
        if (roll < 7) begin
          it = load_item(int'($urandom_range(65535)), int'($urandom_range(65535)));
        end else begin
          it = tick_item();
          moved++;
        end
      end else if (roll < 8) begin
        it = tick_item();
      end else if (roll < 12) begin
        it = load_item(int'($signed(cur_a)), int'($signed(cur_b)));
      end else begin
        roll = $urandom_range(99);
        span = (roll < 75) ? 4 : ((roll < 98) ? 40 : 600);
        it   = load_item(near_coord(cur_a, span), near_coord(cur_b, span));
        moved++;
      end
      send_item(it, 1'b0, '0);
    end

    // Finish the running move.
    while (moves_left != 0) send_item(tick_item(), 1'b0, '0);

    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_steps.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("two_axis_line_step_generator test passed");
    end else begin
      $display("two_axis_line_step_generator test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tals_pkg.sv
hw/rtl/two_axis_line_step_generator.sv
hw/rtl/tals_checker.sv
tb/sv/testbench.sv
